@@ hw/rtl/hufd_pkg.sv @@
// Package for the Huffman archive decoder: payload structs, command and status
// structs, phase and operation codes, node entry layout constants.
// No dependencies.
package hufd_pkg;

   localparam int MAX_SYMBOLS_DEF = 256;
   localparam int IDX_W           = 9;
   localparam int ENTRY_W         = 27;
   localparam int LEAF_BIT        = 26;
   localparam int MAX_EMIT        = 8;

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_TREE   = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   localparam logic [3:0] OP_NONE     = 4'd0;
   localparam logic [3:0] OP_LOAD     = 4'd1;
   localparam logic [3:0] OP_HDR      = 4'd2;
   localparam logic [3:0] OP_TREE1    = 4'd3;
   localparam logic [3:0] OP_MRG_RD1  = 4'd4;
   localparam logic [3:0] OP_MRG_RD2  = 4'd5;
   localparam logic [3:0] OP_MRG_PUSH = 4'd6;
   localparam logic [3:0] OP_DATA_RD  = 4'd7;
   localparam logic [3:0] OP_DATA_RES = 4'd8;
   localparam logic [3:0] OP_OUT_NEXT = 4'd9;
   localparam logic [3:0] OP_OUT_DONE = 4'd10;

   typedef struct packed {
      logic [7:0] archive_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       symbol_valid;
      logic       run_last;
      logic       archive_end;
      logic       malformed;
   } rsp_type;

   typedef struct packed {
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic [1:0] phase;
      logic       left_nz;
      logic       cur_bit;
      logic       pend_nz;
      logic       lvl_lt2;
      logic       last_out;
   } status_type;

endpackage

@@ hw/rtl/hufd_datapath.sv @@
// Datapath of the Huffman archive decoder: archive state, node table memory,
// build stack memory and result buffer, driven by controller commands.
// Depends on hufd_pkg.
module hufd_datapath #(
   parameter int MAX_SYMBOLS = hufd_pkg::MAX_SYMBOLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  hufd_pkg::req_type   req_data,
   input  hufd_pkg::cmd_type   cmd,
   output hufd_pkg::status_type status,
   output hufd_pkg::rsp_type   rsp_data
);

   localparam int NodeDepth = 2 * MAX_SYMBOLS - 1;
   localparam int LvlW      = $clog2(MAX_SYMBOLS + 1);
   localparam int SaW       = $clog2(MAX_SYMBOLS);
   localparam logic [8:0]      NodeLim = 9'(NodeDepth);
   localparam logic [LvlW-1:0] LvlMax  = LvlW'(MAX_SYMBOLS);
   localparam logic [8:0]      SymMax  = 9'(MAX_SYMBOLS);

   logic [1:0]      phase_ff, phase_in;
   logic [7:0]      held_ff, held_in;
   logic            held_vld_ff, held_vld_in;
   logic [8:0]      sym_ff, sym_in;
   logic [8:0]      leaves_ff, leaves_in;
   logic [3:0]      pend_ff, pend_in;
   logic [7:0]      shift_ff, shift_in;
   logic [8:0]      node_cnt_ff, node_cnt_in;
   logic [LvlW-1:0] lvl_ff, lvl_in;
   logic            err_ff, err_in;
   logic [7:0]      work_ff, work_in;
   logic [3:0]      left_ff, left_in;
   logic            fin_ff, fin_in;
   logic [17:0]     cur_ff, cur_in;
   logic [17:0]     root_ff, root_in;
   logic [8:0]      r_ff, r_in;
   logic            oob_ff, oob_in;
   logic [3:0]      n_ff, n_in;
   logic [2:0]      idx_ff, idx_in;
   logic [7:0]      em_ff [hufd_pkg::MAX_EMIT];

   logic [hufd_pkg::ENTRY_W-1:0] node_mem [NodeDepth];
   logic [hufd_pkg::ENTRY_W-1:0] node_rdata_ff;
   logic [8:0]                   stk_mem [MAX_SYMBOLS];
   logic [8:0]                   stk_rdata_ff;

   logic                         node_we, stk_we, em_we;
   logic [8:0]                   node_raddr;
   logic [SaW-1:0]               stk_raddr;
   logic [hufd_pkg::ENTRY_W-1:0] push_entry, ce;
   logic [LvlW-1:0]              base;
   logic                         push_req, done_chk, consume;
   logic                         bit_c;
   logic [8:0]                   child_c, cnt9, expected;
   logic [7:0]                   shift_c, sat_c;
   logic [LvlW-1:0]              lvl_m1, lvl_m2;

   assign bit_c   = work_ff[7];
   assign child_c = bit_c ? cur_ff[8:0] : cur_ff[17:9];
   assign shift_c = {shift_ff[6:0], bit_c};
   assign lvl_m1  = lvl_ff - LvlW'(1);
   assign lvl_m2  = lvl_ff - LvlW'(2);
   assign ce      = oob_ff ? '0 : node_rdata_ff;

   always_comb begin
      if (req_data.archive_byte == 8'd0) begin
         sat_c = 8'd1;
      end else if (req_data.archive_byte > 8'd8) begin
         sat_c = 8'd8;
      end else begin
         sat_c = req_data.archive_byte;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      held_in     = held_ff;
      held_vld_in = held_vld_ff;
      sym_in      = sym_ff;
      leaves_in   = leaves_ff;
      pend_in     = pend_ff;
      shift_in    = shift_ff;
      node_cnt_in = node_cnt_ff;
      lvl_in      = lvl_ff;
      err_in      = err_ff;
      work_in     = work_ff;
      left_in     = left_ff;
      fin_in      = fin_ff;
      cur_in      = cur_ff;
      root_in     = root_ff;
      r_in        = r_ff;
      oob_in      = oob_ff;
      n_in        = n_ff;
      idx_in      = idx_ff;
      node_we     = 1'b0;
      stk_we      = 1'b0;
      em_we       = 1'b0;
      node_raddr  = '0;
      stk_raddr   = '0;
      push_req    = 1'b0;
      push_entry  = '0;
      base        = lvl_ff;
      done_chk    = 1'b0;
      consume     = 1'b0;
      cnt9        = '0;
      expected    = (sym_ff == 9'd1) ? 9'd2 : sym_ff;

      case (cmd.op)
         hufd_pkg::OP_LOAD: begin
            fin_in  = req_data.final_byte;
            n_in    = '0;
            idx_in  = '0;
            work_in = held_ff;
            if (req_data.final_byte) begin
               left_in = held_vld_ff ? sat_c[3:0] : 4'd0;
            end else begin
               left_in     = held_vld_ff ? 4'd8 : 4'd0;
               held_in     = req_data.archive_byte;
               held_vld_in = 1'b1;
            end
         end
         hufd_pkg::OP_HDR: begin
            consume  = 1'b1;
            shift_in = shift_c;
            pend_in  = pend_ff + 4'd1;
            if (pend_ff == 4'd7) begin
               cnt9 = (shift_c == 8'd0) ? 9'd256 : {1'b0, shift_c};
               if (cnt9 > SymMax) begin
                  cnt9   = SymMax;
                  err_in = 1'b1;
               end
               sym_in   = cnt9;
               pend_in  = '0;
               shift_in = '0;
               phase_in = hufd_pkg::PH_TREE;
            end
         end
         hufd_pkg::OP_TREE1: begin
            consume = 1'b1;
            if (pend_ff != 4'd0) begin
               shift_in = shift_c;
               pend_in  = pend_ff - 4'd1;
               if (pend_ff == 4'd1) begin
                  push_req   = 1'b1;
                  push_entry = {1'b1, shift_c, 18'd0};
                  base       = lvl_ff;
                  if (leaves_ff != 9'd511) begin
                     leaves_in = leaves_ff + 9'd1;
                  end
                  done_chk = 1'b1;
               end
            end else if (bit_c) begin
               pend_in  = 4'd8;
               shift_in = '0;
            end else begin
               err_in = 1'b1;
            end
         end
         hufd_pkg::OP_MRG_RD1: begin
            stk_raddr = lvl_m1[SaW-1:0];
         end
         hufd_pkg::OP_MRG_RD2: begin
            r_in      = stk_rdata_ff;
            stk_raddr = lvl_m2[SaW-1:0];
         end
         hufd_pkg::OP_MRG_PUSH: begin
            consume    = 1'b1;
            push_req   = 1'b1;
            push_entry = {1'b0, 8'd0, stk_rdata_ff, r_ff};
            base       = lvl_m2;
            done_chk   = 1'b1;
         end
         hufd_pkg::OP_DATA_RD: begin
            node_raddr = child_c;
            oob_in     = (child_c >= NodeLim);
         end
         hufd_pkg::OP_DATA_RES: begin
            consume = 1'b1;
            if (ce[hufd_pkg::LEAF_BIT]) begin
               if (n_ff < 4'd8) begin
                  em_we = 1'b1;
                  n_in  = n_ff + 4'd1;
               end
               cur_in = root_ff;
            end else begin
               cur_in = ce[17:0];
            end
         end
         hufd_pkg::OP_OUT_NEXT: begin
            idx_in = idx_ff + 3'd1;
         end
         hufd_pkg::OP_OUT_DONE: begin
            if (fin_ff) begin
               phase_in    = hufd_pkg::PH_HEADER;
               held_in     = '0;
               held_vld_in = 1'b0;
               sym_in      = '0;
               leaves_in   = '0;
               pend_in     = '0;
               shift_in    = '0;
               node_cnt_in = '0;
               lvl_in      = '0;
               err_in      = 1'b0;
            end
         end
         default: begin
         end
      endcase

      if (push_req) begin
         lvl_in = base;
         if ((node_cnt_ff < NodeLim) && (base < LvlMax)) begin
            node_we     = 1'b1;
            stk_we      = 1'b1;
            lvl_in      = base + LvlW'(1);
            node_cnt_in = node_cnt_ff + 9'd1;
            if (base == '0) begin
               root_in = push_entry[17:0];
            end
         end else begin
            err_in = 1'b1;
         end
      end

      if (done_chk && (leaves_in >= expected) && (lvl_in == LvlW'(1))) begin
         phase_in = hufd_pkg::PH_DATA;
         cur_in   = root_in;
      end

      if (consume) begin
         work_in = {work_ff[6:0], 1'b0};
         left_in = left_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= hufd_pkg::PH_HEADER;
         held_ff     <= '0;
         held_vld_ff <= 1'b0;
         sym_ff      <= '0;
         leaves_ff   <= '0;
         pend_ff     <= '0;
         shift_ff    <= '0;
         node_cnt_ff <= '0;
         lvl_ff      <= '0;
         err_ff      <= 1'b0;
         left_ff     <= '0;
         fin_ff      <= 1'b0;
         n_ff        <= '0;
         idx_ff      <= '0;
         cur_ff      <= '0;
      end else begin
         phase_ff    <= phase_in;
         held_ff     <= held_in;
         held_vld_ff <= held_vld_in;
         sym_ff      <= sym_in;
         leaves_ff   <= leaves_in;
         pend_ff     <= pend_in;
         shift_ff    <= shift_in;
         node_cnt_ff <= node_cnt_in;
         lvl_ff      <= lvl_in;
         err_ff      <= err_in;
         left_ff     <= left_in;
         fin_ff      <= fin_in;
         n_ff        <= n_in;
         idx_ff      <= idx_in;
         cur_ff      <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      root_ff <= root_in;
      r_ff    <= r_in;
      oob_ff  <= oob_in;
      if (em_we) begin
         em_ff[n_ff[2:0]] <= ce[25:18];
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_cnt_ff] <= push_entry;
      end
      node_rdata_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[base[SaW-1:0]] <= node_cnt_ff;
      end
      stk_rdata_ff <= stk_mem[stk_raddr];
   end

   assign status.phase    = phase_ff;
   assign status.left_nz  = (left_ff != 4'd0);
   assign status.cur_bit  = bit_c;
   assign status.pend_nz  = (pend_ff != 4'd0);
   assign status.lvl_lt2  = (lvl_ff < LvlW'(2));
   assign status.last_out = (n_ff == 4'd0) || ({1'b0, idx_ff} == n_ff - 4'd1);

   assign rsp_data.symbol       = (n_ff == 4'd0) ? 8'd0 : em_ff[idx_ff];
   assign rsp_data.symbol_valid = (n_ff != 4'd0);
   assign rsp_data.run_last     = status.last_out;
   assign rsp_data.archive_end  = fin_ff;
   assign rsp_data.malformed    = err_ff;

endmodule

@@ hw/rtl/hufd_ctrl.sv @@
// Controller of the Huffman archive decoder: sequences bit steps, memory read
// waits and result delivery. Depends on hufd_pkg.
module hufd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  hufd_pkg::status_type status,
   output hufd_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_BIT   = 3'd1;
   localparam logic [2:0] S_MRG1  = 3'd2;
   localparam logic [2:0] S_MRG2  = 3'd3;
   localparam logic [2:0] S_DWAIT = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = hufd_pkg::OP_NONE;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = hufd_pkg::OP_LOAD;
               state_in = S_BIT;
            end
         end
         S_BIT: begin
            if (!status.left_nz) begin
               state_in = S_EMIT;
            end else begin
               case (status.phase)
                  hufd_pkg::PH_HEADER: cmd.op = hufd_pkg::OP_HDR;
                  hufd_pkg::PH_TREE: begin
                     if (status.pend_nz || status.cur_bit || status.lvl_lt2) begin
                        cmd.op = hufd_pkg::OP_TREE1;
                     end else begin
                        cmd.op   = hufd_pkg::OP_MRG_RD1;
                        state_in = S_MRG1;
                     end
                  end
                  default: begin
                     cmd.op   = hufd_pkg::OP_DATA_RD;
                     state_in = S_DWAIT;
                  end
               endcase
            end
         end
         S_MRG1: begin
            cmd.op   = hufd_pkg::OP_MRG_RD2;
            state_in = S_MRG2;
         end
         S_MRG2: begin
            cmd.op   = hufd_pkg::OP_MRG_PUSH;
            state_in = S_BIT;
         end
         S_DWAIT: begin
            cmd.op   = hufd_pkg::OP_DATA_RES;
            state_in = S_BIT;
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last_out) begin
                  cmd.op   = hufd_pkg::OP_OUT_DONE;
                  state_in = S_IDLE;
               end else begin
                  cmd.op = hufd_pkg::OP_OUT_NEXT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_load_starts_bits: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_BIT))
      else $error("accepted item did not start bit processing");

   a_merge_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MRG1) |=> (state_ff == S_MRG2))
      else $error("merge read sequence broken");

   a_data_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DWAIT) |=> (state_ff == S_BIT))
      else $error("data step did not resolve after one wait");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

endmodule

@@ hw/rtl/huffman_archive_decoder_unit.sv @@
// Top level of the Huffman archive decoder: connects controller and datapath.
// Depends on hufd_pkg, hufd_ctrl and hufd_datapath.
//
// Channel  Direction  Handshake             Payload
// req      in         req_valid/req_ready   hufd_pkg::req_type (archive_byte, final_byte)
// rsp      out        rsp_valid/rsp_ready   hufd_pkg::rsp_type (symbol .. malformed)
//
// An item is loaded, then each header bit and each tree bit is processed; a
// merge bit makes two build stack reads and then the push, and each data bit
// makes a node table read, then the tree step. A final check finds no bits
// left, after which each result item waits until the consumer takes it.
// Reset clears all control state; the node table and build stack hold no
// reset and are only read where they were written for this archive.
// A stall on the result channel holds the block; no new item is taken until
// the last result of the current item has been delivered.
module huffman_archive_decoder_unit #(
   parameter int MAX_SYMBOLS = hufd_pkg::MAX_SYMBOLS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hufd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hufd_pkg::rsp_type rsp_data
);

   // Commands flow from the controller to the datapath; status flows back.
   hufd_pkg::cmd_type    cmd;
   hufd_pkg::status_type status;

   hufd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath owns the archive state and both memories; results are read
   // straight from its registered buffer, so the payload is stable while held.
   hufd_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule
